// ===== hdl/ffpa_pkg.sv =====
// Shared types and constants for the first-fit page allocator.
// Used by ffpa_ctrl, ffpa_datapath and first_fit_page_allocator; no dependencies.
`timescale 1ns / 1ps

package ffpa_pkg;

    localparam int NUM_PAGES     = 512;
    localparam int TABLE_ENTRIES = 512;
    localparam int PAGE_W        = $clog2(NUM_PAGES);
    localparam int CNT_W         = $clog2(NUM_PAGES + 1);
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int ECNT_W        = $clog2(TABLE_ENTRIES + 1);
    localparam int ROW_W         = 32;
    localparam int BIT_W         = $clog2(ROW_W);
    localparam int ROWS          = NUM_PAGES / ROW_W;
    localparam int ROW_IDX_W     = PAGE_W - BIT_W;
    localparam int MP_W          = PAGE_W + 2;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_TABLE_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        RES_OK_NEW,
        RES_OK_GROW,
        RES_OK_SHRINK,
        RES_NO_SPACE,
        RES_FULL
    } res_code_t;

    typedef enum logic [1:0] {
        MK_NEW_RUN,
        MK_OLD_CLR,
        MK_OLD_SET,
        MK_TAIL
    } mark_src_t;

    typedef enum logic [2:0] {
        MODE_NEW,
        MODE_GROW_CLR,
        MODE_GROW_SET,
        MODE_RESTORE,
        MODE_SHRINK
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LK_RD,
        S_LK_CHK,
        S_HIT,
        S_NEW,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_MARK_INIT,
        S_MARK_CHK,
        S_MARK_RD,
        S_MARK_WR,
        S_TBL_APPEND,
        S_TBL_RD_LAST,
        S_TBL_WR_IDX,
        S_TBL_WR_LAST
    } state_t;

    typedef struct packed {
        logic      load;
        logic      lk_first;
        logic      lk_rd;
        logic      lk_next;
        logic      lk_hit;
        logic      scan_init;
        logic      scan_rd;
        logic      scan_chk;
        logic      mark_init;
        mark_src_t mark_src;
        logic      mark_rd;
        logic      mark_wr;
        logic      tbl_append;
        logic      tbl_rd_last;
        logic      tbl_wr_idx;
        logic      tbl_wr_last;
        logic      out_load;
        res_code_t res_code;
    } cmd_t;

    typedef struct packed {
        logic resize_known;
        logic lk_match;
        logic lk_last;
        logic grow;
        logic table_full;
        logic scan_found;
        logic scan_end;
        logic mark_done;
        logic out_free;
    } stat_t;

endpackage

// ===== hdl/ffpa_ctrl.sv =====
// Sequencer for the first-fit page allocator: steps each request through
// lookup, search, marking and table update. Depends on ffpa_pkg.
`timescale 1ns / 1ps

module ffpa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  ffpa_pkg::stat_t stat,
    output ffpa_pkg::cmd_t  cmd,
    output logic           busy_fin
);
    import ffpa_pkg::*;

    state_t    state_reg, state_next;
    mode_t     mode_reg, mode_next;
    res_code_t code_reg, code_next;
    logic      fin_reg, fin_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_NEW;
            code_reg  <= RES_OK_NEW;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            code_reg  <= code_next;
            fin_reg   <= fin_next;
        end
    end

    // The finishing step is a flag beside S_IDLE: the result waits in it
    // until the output register is free.
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        code_next  = code_reg;
        fin_next   = fin_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (fin_reg)
                begin
                    if (stat.out_free)
                        fin_next = 1'b0;
                end
                else if (s_tvalid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:   state_next = stat.resize_known ? S_LK_RD : S_NEW;
            S_LK_RD:      state_next = S_LK_CHK;
            S_LK_CHK:
            begin
                if (stat.lk_match)
                    state_next = S_HIT;
                else if (stat.lk_last)
                    state_next = S_NEW;
                else
                    state_next = S_LK_RD;
            end
            S_HIT:
            begin
                mode_next  = stat.grow ? MODE_GROW_CLR : MODE_SHRINK;
                state_next = S_MARK_INIT;
            end
            S_NEW:
            begin
                mode_next = MODE_NEW;
                if (stat.table_full)
                begin
                    code_next  = RES_FULL;
                    fin_next   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:    state_next = S_SCAN_CHK;
            S_SCAN_CHK:
            begin
                if (stat.scan_found)
                begin
                    if (mode_reg == MODE_GROW_CLR)
                        mode_next = MODE_GROW_SET;
                    state_next = S_MARK_INIT;
                end
                else if (stat.scan_end)
                begin
                    if (mode_reg == MODE_GROW_CLR)
                    begin
                        mode_next  = MODE_RESTORE;
                        state_next = S_MARK_INIT;
                    end
                    else
                    begin
                        code_next  = RES_NO_SPACE;
                        fin_next   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_MARK_INIT:  state_next = S_MARK_CHK;
            S_MARK_CHK:
            begin
                if (!stat.mark_done)
                    state_next = S_MARK_RD;
                else
                begin
                    unique case (mode_reg)
                        MODE_NEW:      state_next = S_TBL_APPEND;
                        MODE_GROW_CLR: state_next = S_SCAN_RD;
                        MODE_GROW_SET:
                        begin
                            code_next  = RES_OK_GROW;
                            state_next = S_TBL_RD_LAST;
                        end
                        MODE_RESTORE:
                        begin
                            code_next  = RES_NO_SPACE;
                            fin_next   = 1'b1;
                            state_next = S_IDLE;
                        end
                        MODE_SHRINK:
                        begin
                            code_next  = RES_OK_SHRINK;
                            state_next = S_TBL_RD_LAST;
                        end
                        default:       state_next = S_IDLE;
                    endcase
                end
            end
            S_MARK_RD:    state_next = S_MARK_WR;
            S_MARK_WR:    state_next = S_MARK_CHK;
            S_TBL_APPEND:
            begin
                code_next  = RES_OK_NEW;
                fin_next   = 1'b1;
                state_next = S_IDLE;
            end
            S_TBL_RD_LAST: state_next = S_TBL_WR_IDX;
            S_TBL_WR_IDX:  state_next = S_TBL_WR_LAST;
            S_TBL_WR_LAST:
            begin
                fin_next   = 1'b1;
                state_next = S_IDLE;
            end
            default:       state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.res_code = code_reg;
        s_tready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready     = !fin_reg;
                cmd.load     = !fin_reg && s_tvalid;
                cmd.out_load = fin_reg && stat.out_free;
            end
            S_DISPATCH:    cmd.lk_first = stat.resize_known;
            S_LK_RD:       cmd.lk_rd    = 1'b1;
            S_LK_CHK:
            begin
                cmd.lk_hit  = stat.lk_match;
                cmd.lk_next = !stat.lk_match;
            end
            S_HIT:         cmd.lk_hit = 1'b0;
            S_NEW:         cmd.scan_init = !stat.table_full;
            S_SCAN_RD:     cmd.scan_rd  = 1'b1;
            S_SCAN_CHK:    cmd.scan_chk = 1'b1;
            S_MARK_INIT:
            begin
                cmd.mark_init = 1'b1;
                unique case (mode_reg)
                    MODE_GROW_CLR: cmd.mark_src = MK_OLD_CLR;
                    MODE_RESTORE:  cmd.mark_src = MK_OLD_SET;
                    MODE_SHRINK:   cmd.mark_src = MK_TAIL;
                    default:       cmd.mark_src = MK_NEW_RUN;
                endcase
            end
            S_MARK_CHK:    cmd.scan_init = stat.mark_done && (mode_reg == MODE_GROW_CLR);
            S_MARK_RD:     cmd.mark_rd     = 1'b1;
            S_MARK_WR:     cmd.mark_wr     = 1'b1;
            S_TBL_APPEND:  cmd.tbl_append  = 1'b1;
            S_TBL_RD_LAST: cmd.tbl_rd_last = 1'b1;
            S_TBL_WR_IDX:  cmd.tbl_wr_idx  = 1'b1;
            S_TBL_WR_LAST: cmd.tbl_wr_last = 1'b1;
            default:       cmd.lk_rd = 1'b0;
        endcase
    end

    assign busy_fin = fin_reg;

endmodule

// ===== hdl/ffpa_datapath.sv =====
// Datapath of the first-fit page allocator: request registers, page bitmap,
// block table, search and marking counters, result register. Depends on ffpa_pkg.
`timescale 1ns / 1ps

module ffpa_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ffpa_pkg::cmd_t          cmd,
    output ffpa_pkg::stat_t         stat,
    input  logic                    in_req_type,
    input  logic [ffpa_pkg::PAGE_W-1:0] in_block_start,
    input  logic [ffpa_pkg::CNT_W-1:0]  in_page_count,
    output logic                    out_valid,
    input  logic                    out_ready,
    output ffpa_pkg::status_t       out_status,
    output logic [ffpa_pkg::PAGE_W-1:0] out_result_start,
    output logic                    out_copy_needed,
    output logic [ffpa_pkg::PAGE_W-1:0] out_copy_from,
    output logic [ffpa_pkg::CNT_W-1:0]  out_copy_pages
);
    import ffpa_pkg::*;

    typedef struct packed {
        logic [PAGE_W-1:0] start;
        logic [CNT_W-1:0]  pages;
    } entry_t;

    // Request and working registers
    logic              req_reg;
    logic [PAGE_W-1:0] start_reg;
    logic [CNT_W-1:0]  want_reg;
    logic [CNT_W-1:0]  old_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [ECNT_W-1:0] count_reg;
    logic [PAGE_W-1:0] sp_reg;
    logic [CNT_W-1:0]  run_reg;
    logic [PAGE_W-1:0] first_reg;
    logic [MP_W-1:0]   mp_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic              val_reg;

    // Page bitmap: rows of ROW_W pages, with a valid flag per row so that
    // an unwritten row reads as all free.
    logic [ROW_W-1:0]     bm_mem [ROWS];
    logic [ROWS-1:0]      row_valid_reg;
    logic [ROW_W-1:0]     bm_rd_reg;
    logic                 bm_rv_reg;
    logic [ROW_IDX_W-1:0] bm_raddr;
    logic [ROW_W-1:0]     bm_row;
    logic [ROW_W-1:0]     bm_wdata;
    logic [BIT_W-1:0]     mbit;

    // Block table
    entry_t            tbl_mem [TABLE_ENTRIES];
    entry_t            tbl_rd_reg;
    logic [IDX_W-1:0]  tbl_raddr;
    logic [IDX_W-1:0]  tbl_waddr;
    entry_t            tbl_wdata;
    logic              tbl_we;
    logic [IDX_W-1:0]  last_idx;

    logic              page_free;
    logic [CNT_W:0]    run_inc;
    logic              grow;

    assign last_idx = IDX_W'(count_reg - ECNT_W'(1));
    assign grow     = old_reg < want_reg;
    assign bm_row   = bm_rv_reg ? bm_rd_reg : '0;
    assign page_free = !bm_row[sp_reg[BIT_W-1:0]];
    assign run_inc  = {1'b0, run_reg} + (CNT_W+1)'(1);
    assign mbit     = mp_reg[BIT_W-1:0];

    always_comb
    begin
        bm_wdata       = bm_row;
        bm_wdata[mbit] = val_reg;
        bm_raddr       = cmd.mark_rd ? mp_reg[PAGE_W-1:BIT_W] : sp_reg[PAGE_W-1:BIT_W];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd || cmd.mark_rd)
        begin
            bm_rd_reg <= bm_mem[bm_raddr];
        end
        if (cmd.mark_wr)
        begin
            bm_mem[mp_reg[PAGE_W-1:BIT_W]] <= bm_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            bm_rv_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.scan_rd || cmd.mark_rd)
                bm_rv_reg <= row_valid_reg[bm_raddr];
            if (cmd.mark_wr)
                row_valid_reg[mp_reg[PAGE_W-1:BIT_W]] <= 1'b1;
        end
    end

    // Table port muxes
    always_comb
    begin
        tbl_raddr = cmd.tbl_rd_last ? last_idx : idx_reg;
        tbl_we    = cmd.tbl_append || cmd.tbl_wr_idx || cmd.tbl_wr_last;
        tbl_waddr = idx_reg;
        tbl_wdata = tbl_rd_reg;
        if (cmd.tbl_append)
        begin
            tbl_waddr = count_reg[IDX_W-1:0];
            tbl_wdata = '{start: first_reg, pages: want_reg};
        end
        else if (cmd.tbl_wr_last)
        begin
            tbl_waddr = last_idx;
            tbl_wdata = '{start: (grow ? first_reg : start_reg), pages: want_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lk_rd || cmd.tbl_rd_last)
        begin
            tbl_rd_reg <= tbl_mem[tbl_raddr];
        end
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
    end

    // Payload and counter registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= in_req_type;
            start_reg <= in_block_start;
            want_reg  <= in_page_count;
        end
        if (cmd.lk_first)
            idx_reg <= '0;
        else if (cmd.lk_next)
            idx_reg <= idx_reg + IDX_W'(1);
        if (cmd.lk_hit)
            old_reg <= tbl_rd_reg.pages;
        if (cmd.scan_init)
        begin
            sp_reg  <= '0;
            run_reg <= '0;
        end
        else if (cmd.scan_chk)
        begin
            sp_reg <= sp_reg + PAGE_W'(1);
            if (page_free)
            begin
                run_reg <= run_inc[CNT_W-1:0];
                if (run_reg == '0)
                    first_reg <= sp_reg;
            end
            else
            begin
                run_reg <= '0;
            end
        end
        if (cmd.mark_init)
        begin
            case (cmd.mark_src)
                MK_NEW_RUN:
                begin
                    mp_reg  <= MP_W'(first_reg);
                    rem_reg <= want_reg;
                    val_reg <= 1'b1;
                end
                MK_OLD_CLR:
                begin
                    mp_reg  <= MP_W'(start_reg);
                    rem_reg <= old_reg;
                    val_reg <= 1'b0;
                end
                MK_OLD_SET:
                begin
                    mp_reg  <= MP_W'(start_reg);
                    rem_reg <= old_reg;
                    val_reg <= 1'b1;
                end
                default:
                begin
                    mp_reg  <= MP_W'(start_reg) + MP_W'(want_reg);
                    rem_reg <= old_reg - want_reg;
                    val_reg <= 1'b0;
                end
            endcase
        end
        else if (cmd.mark_wr)
        begin
            mp_reg  <= mp_reg + MP_W'(1);
            rem_reg <= rem_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.tbl_append)
            count_reg <= count_reg + ECNT_W'(1);
    end

    // Result register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status       <= ST_OK;
            out_result_start <= '0;
            out_copy_needed  <= 1'b0;
            out_copy_from    <= '0;
            out_copy_pages   <= '0;
            case (cmd.res_code)
                RES_OK_NEW:    out_result_start <= first_reg;
                RES_OK_SHRINK: out_result_start <= start_reg;
                RES_OK_GROW:
                begin
                    out_result_start <= first_reg;
                    out_copy_needed  <= 1'b1;
                    out_copy_from    <= start_reg;
                    out_copy_pages   <= old_reg;
                end
                RES_NO_SPACE:  out_status <= ST_NO_SPACE;
                RES_FULL:      out_status <= ST_TABLE_FULL;
                default:       out_status <= ST_OK;
            endcase
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        stat.resize_known = req_reg && (count_reg != '0);
        stat.lk_match     = tbl_rd_reg.start == start_reg;
        stat.lk_last      = idx_reg == last_idx;
        stat.grow         = grow;
        stat.table_full   = count_reg == ECNT_W'(TABLE_ENTRIES);
        stat.scan_found   = page_free && (run_inc == (CNT_W+1)'(want_reg));
        stat.scan_end     = sp_reg == PAGE_W'(NUM_PAGES - 1);
        stat.mark_done    = (rem_reg == '0) || (mp_reg >= MP_W'(NUM_PAGES));
        stat.out_free     = !out_valid_reg || out_ready;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ECNT_W'(TABLE_ENTRIES))
        else $error("block table count beyond capacity");

    a_append_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tbl_append |=> count_reg == $past(count_reg) + ECNT_W'(1))
        else $error("append did not advance the table count");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result load did not raise valid");

    a_copy_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_copy_needed) |-> (out_status == ST_OK))
        else $error("copy reported on a failed request");

endmodule

// ===== hdl/first_fit_page_allocator.sv =====
// Top level of the first-fit page allocator: joins the sequencer and the datapath
// and packs the stream buses. Depends on ffpa_pkg, ffpa_ctrl and ffpa_datapath.
//
//  Bus      Dir  tdata fields (low bit up)                         tuser
//  s_axis   in   block_start[8:0], page_count[18:9], zero[23:19]    req_type[0]
//  m_axis   out  result_start[8:0], copy_needed[9], copy_from[18:10],
//                copy_pages[28:19], zero[31:29]                     status[1:0]
//
// A request passes through dispatch, a lookup over the entries of the block table,
// a first-fit search over the pages and the marking or freeing of pages; a grow
// after a full lookup scans the whole table, frees the old run, searches the bitmap
// and marks the new run. Reset clears the bitmap's row flags, the table count and
// all control state at once; no clearing pass is needed. A new request is taken
// while the previous result still waits on m_tready.
`timescale 1ns / 1ps

module first_fit_page_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // block_start[8:0], page_count[18:9]
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_start, copy_needed, copy_from, copy_pages
    output logic [1:0]  m_tuser    // status
);
    import ffpa_pkg::*;

    cmd_t              cmd;
    stat_t             stat;
    logic              fin;
    status_t           status;
    logic [PAGE_W-1:0] result_start;
    logic              copy_needed;
    logic [PAGE_W-1:0] copy_from;
    logic [CNT_W-1:0]  copy_pages;

    ffpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd),
        .busy_fin (fin)
    );

    ffpa_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .in_req_type      (s_tuser),
        .in_block_start   (s_tdata[8:0]),
        .in_page_count    (s_tdata[18:9]),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_status       (status),
        .out_result_start (result_start),
        .out_copy_needed  (copy_needed),
        .out_copy_from    (copy_from),
        .out_copy_pages   (copy_pages)
    );

    assign m_tdata = {3'b000, copy_pages, copy_from, copy_needed, result_start};
    assign m_tuser = status;

    // A result waiting to be loaded always blocks new input.
    a_fin_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        fin |-> !s_tready)
        else $error("input accepted while a result is pending");

endmodule
